### design/tsrc_pkg.sv
// Package for the bracketed timestamp scanner.
// Holds the result word type, character codes and the time scale constants.
// No dependencies; imported by timestamp_scan_range_check.
package tsrc_pkg;

	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

	localparam logic [15:0] CH_DIGIT0 = 16'h0030;
	localparam logic [15:0] CH_DIGIT9 = 16'h0039;
	localparam logic [15:0] CH_COLON  = 16'h003A;
	localparam logic [15:0] CH_LBRACK = 16'h005B;
	localparam logic [15:0] CH_RBRACK = 16'h005D;

	localparam logic [18:0] SEC_PER_HOUR = 19'd3600;
	localparam logic [18:0] SEC_PER_MIN  = 19'd60;
	localparam logic [28:0] MS_PER_SEC   = 29'd1000;

	localparam logic KIND_STAMP   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [28:0] ms;
		logic        oor;
		logic        err;
		logic        last;
	} result_t;

endpackage

### design/timestamp_scan_range_check.sv
// Bracketed timestamp scanner with range check against a video duration.
// Scanner state machine, time arithmetic pipeline and a small result queue.
// Depends on tsrc_pkg.
//
// Usage: text enters one UTF-16 code unit per word on the input channel
// (in_valid/in_ready, char_code, end_of_text). Each completed [m:ss],
// [mm:ss], [h:mm:ss] or [hh:mm:ss] stamp produces one result word with its
// value in milliseconds and an out-of-range flag. The word that carries
// end_of_text also produces a verdict word with the sticky error flag; when
// it closes a stamp too, the stamp word comes first. The duration register is
// written through cfg_valid/cfg_ready/duration_ms, always ready; the user must
// write it only while idle, as the block does not enforce this. Throughput:
// one character per cycle while in_ready is high. A result reaches out_valid
// through the scanner register, the seconds stage, the millisecond multiply
// stage and then the result queue. The queue holds eight words; in_ready
// drops when fewer than two places are free, counting words still in the
// pipeline, so a stalled receiver backs up the input and nothing is lost.
// Reset clears the scanner, the sticky flag, the queue and the duration.
module timestamp_scan_range_check
	import tsrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] duration_ms,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [28:0] timestamp_ms,
	output logic        out_of_range,
	output logic        error_seen,
	output logic        last
);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_OPEN = 4'd1;
	localparam logic [3:0] PH_A1   = 4'd2;
	localparam logic [3:0] PH_A2   = 4'd3;
	localparam logic [3:0] PH_C1   = 4'd4;
	localparam logic [3:0] PH_B1   = 4'd5;
	localparam logic [3:0] PH_B2   = 4'd6;
	localparam logic [3:0] PH_C2   = 4'd7;
	localparam logic [3:0] PH_D1   = 4'd8;
	localparam logic [3:0] PH_D2   = 4'd9;

	logic [31:0] dur_q;
	logic [3:0]  phase_q, phase_d;
	logic [6:0]  f1_q, f2_q, f3_q, f1_d, f2_d, f3_d;
	logic        viol_q;

	logic        accept;
	logic        is_dig;
	logic [3:0]  dval;
	logic        stamp;
	logic [6:0]  h_sel, m_sel, s_sel;

	logic        stamp_s1, eot_s1;
	logic [6:0]  h_s1, m_s1, s_s1;
	logic        stamp_s2, eot_s2;
	logic [18:0] secs_s2;
	logic        stamp_s3, eot_s3;
	logic [28:0] ms_s3;

	logic        oor;
	logic        viol_new;
	result_t     stamp_word, verdict_word;

	result_t     res_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_AW:0]   cnt_q, used_q;
	logic        pop;
	logic [1:0]  n_acc, n_push;
	result_t     head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= '0;
		end else if (cfg_valid) begin
			dur_q <= duration_ms;
		end
	end

	// Scanner: decodes one character against the current match phase.
	assign accept = in_valid && in_ready;
	assign is_dig = (char_code >= CH_DIGIT0) && (char_code <= CH_DIGIT9);
	assign dval   = is_dig ? char_code[3:0] : 4'd0;

	always_comb begin
		phase_d = PH_IDLE;
		f1_d    = f1_q;
		f2_d    = f2_q;
		f3_d    = f3_q;
		stamp   = 1'b0;
		h_sel   = f1_q;
		m_sel   = f2_q;
		s_sel   = f3_q;
		if (char_code == CH_LBRACK) begin
			phase_d = PH_OPEN;
		end else begin
			unique case (phase_q)
				PH_OPEN: begin
					if (is_dig) begin
						f1_d    = {3'd0, dval};
						phase_d = PH_A1;
					end
				end
				PH_A1: begin
					if (is_dig) begin
						f1_d    = 7'(f1_q * 7'd10 + {3'd0, dval});
						phase_d = PH_A2;
					end else if (char_code == CH_COLON) begin
						phase_d = PH_C1;
					end
				end
				PH_A2: begin
					if (char_code == CH_COLON) begin
						phase_d = PH_C1;
					end
				end
				PH_C1: begin
					if (is_dig) begin
						f2_d    = {3'd0, dval};
						phase_d = PH_B1;
					end
				end
				PH_B1: begin
					if (is_dig) begin
						f2_d    = 7'(f2_q * 7'd10 + {3'd0, dval});
						phase_d = PH_B2;
					end else if (char_code == CH_COLON) begin
						phase_d = PH_C2;
					end
				end
				PH_B2: begin
					if (char_code == CH_COLON) begin
						phase_d = PH_C2;
					end else if (char_code == CH_RBRACK) begin
						// Two-field stamp: minutes and seconds.
						stamp = 1'b1;
						h_sel = 7'd0;
						m_sel = f1_q;
						s_sel = f2_q;
					end
				end
				PH_C2: begin
					if (is_dig) begin
						f3_d    = {3'd0, dval};
						phase_d = PH_D1;
					end
				end
				PH_D1: begin
					if (is_dig) begin
						f3_d    = 7'(f3_q * 7'd10 + {3'd0, dval});
						phase_d = PH_D2;
					end
				end
				PH_D2: begin
					if (char_code == CH_RBRACK) begin
						stamp = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (end_of_text) begin
			phase_d = PH_IDLE;
			f1_d    = 7'd0;
			f2_d    = 7'd0;
			f3_d    = 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			f1_q    <= '0;
			f2_q    <= '0;
			f3_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			f1_q    <= f1_d;
			f2_q    <= f2_d;
			f3_q    <= f3_d;
		end
	end

	// Arithmetic pipeline; it never stalls because places are reserved ahead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_s1 <= 1'b0;
			eot_s1   <= 1'b0;
			stamp_s2 <= 1'b0;
			eot_s2   <= 1'b0;
			stamp_s3 <= 1'b0;
			eot_s3   <= 1'b0;
		end else begin
			stamp_s1 <= accept && stamp;
			eot_s1   <= accept && end_of_text;
			stamp_s2 <= stamp_s1;
			eot_s2   <= eot_s1;
			stamp_s3 <= stamp_s2;
			eot_s3   <= eot_s2;
		end
	end

	always_ff @(posedge clk) begin
		h_s1    <= h_sel;
		m_s1    <= m_sel;
		s_s1    <= s_sel;
		secs_s2 <= {12'd0, h_s1} * SEC_PER_HOUR + {12'd0, m_s1} * SEC_PER_MIN
			+ {12'd0, s_s1};
		ms_s3   <= {10'd0, secs_s2} * MS_PER_SEC;
	end

	// Range check and sticky flag, applied in text order at the queue input.
	assign oor      = (dur_q != 32'd0) && ({3'd0, ms_s3} > dur_q);
	assign viol_new = viol_q || (stamp_s3 && oor);

	always_comb begin
		stamp_word.kind = KIND_STAMP;
		stamp_word.ms   = ms_s3;
		stamp_word.oor  = oor;
		stamp_word.err  = viol_new;
		stamp_word.last = !eot_s3;
		verdict_word.kind = KIND_VERDICT;
		verdict_word.ms   = '0;
		verdict_word.oor  = 1'b0;
		verdict_word.err  = viol_new;
		verdict_word.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viol_q <= 1'b0;
		end else if (eot_s3) begin
			viol_q <= 1'b0;
		end else begin
			viol_q <= viol_new;
		end
	end

	// Result queue.
	assign n_acc  = accept ? ({1'b0, stamp} + {1'b0, end_of_text}) : 2'd0;
	assign n_push = {1'b0, stamp_s3} + {1'b0, eot_s3};
	assign pop    = out_valid && out_ready;
	assign in_ready = used_q <= (RES_AW+1)'(RES_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (stamp_s3) begin
			res_q[wr_ptr_q] <= stamp_word;
			if (eot_s3) begin
				res_q[RES_AW'(wr_ptr_q + 1'b1)] <= verdict_word;
			end
		end else if (eot_s3) begin
			res_q[wr_ptr_q] <= verdict_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			used_q   <= '0;
		end else begin
			wr_ptr_q <= RES_AW'(wr_ptr_q + n_push);
			rd_ptr_q <= RES_AW'(rd_ptr_q + {{(RES_AW-1){1'b0}}, pop});
			cnt_q    <= (RES_AW+1)'(cnt_q + n_push - {{RES_AW{1'b0}}, pop});
			used_q   <= (RES_AW+1)'(used_q + n_acc - {{RES_AW{1'b0}}, pop});
		end
	end

	assign out_valid    = cnt_q != '0;
	assign head         = res_q[rd_ptr_q];
	assign result_kind  = head.kind;
	assign timestamp_ms = head.ms;
	assign out_of_range = head.oor;
	assign error_seen   = head.err;
	assign last         = head.last;

endmodule
